@@ rtl/ring_history_buffer_macros.svh @@
// ----------------------------------------------------------------------------
// Ring history buffer assertion macros
// Shared concurrent assertion forms for the history buffer checkers.
// ----------------------------------------------------------------------------
`ifndef RING_HISTORY_BUFFER_MACROS_SVH
`define RING_HISTORY_BUFFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RHB_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RHB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/rhb_pkg.sv @@
// ----------------------------------------------------------------------------
// Ring history buffer package
// Word types, cell control and shared constants.
// ----------------------------------------------------------------------------
package rhb_pkg;

  localparam int RING_DEPTH_DEF    = 512;
  localparam int HISTORY_LIMIT_DEF = 50;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  typedef enum logic {
    MODE_SAVE    = 1'b0,
    MODE_RESTORE = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] colour;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_char;
    logic [BYTE_W-1:0]  out_colour;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] restored_count;
    logic               is_last;
    logic               empty_res;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] colour;
    logic [BYTE_W-1:0] char_code;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SAVE = 2'd1,
    CELL_ROT  = 2'd2
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [COUNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

@@ rtl/ring_history_buffer.sv @@
// ----------------------------------------------------------------------------
// Ring history buffer
// Keeps the most recent character/colour words and replays them oldest first.
// ----------------------------------------------------------------------------
//
//   channel   ports                  handshake
//   -------   --------------------   ------------------------------------
//   request   start, busy, req       word taken when start && !busy
//   result    done, result           word shown for one cycle with done
//
// A save is taken without raising busy; the next word can follow at once.
// A restore holds busy until every stored word has been tapped out, the
// chain rotating one cell per cycle past the tap at cell 0; each result is
// registered and shows in the cycle after its step, back to back. An empty
// restore gives its single result in the cycle after acceptance without raising busy.
// Reset clears the word count and the controller; cell contents are kept.
// The receiver cannot stall, so results never wait.
//
// The history lives in a chain of cells, oldest word in cell 0 and the
// newest in cell count-1. A save drops into the first free cell, or shifts
// the whole chain toward cell 0 once the chain is full. A restore rotates
// the occupied cells: cell 0 is read out and recirculated into cell count-1,
// so after count steps the chain is back as it was.
// ----------------------------------------------------------------------------
module ring_history_buffer import rhb_pkg::*; #(
  parameter int RING_DEPTH    = RING_DEPTH_DEF,
  parameter int HISTORY_LIMIT = HISTORY_LIMIT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  output logic    busy,
  output logic    done,
  output result_t result
);

  // the ring never holds more words than it has slots
  localparam int CELLS = (HISTORY_LIMIT < RING_DEPTH) ? HISTORY_LIMIT : RING_DEPTH;
  localparam logic [COUNT_W-1:0] FULL_C = COUNT_W'(CELLS);

  typedef enum logic {
    ST_IDLE,
    ST_REPLAY
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] count;
  logic [POS_W-1:0]   pos;

  cell_ctrl_t ctrl;
  entry_t     new_entry;
  entry_t     cell_q [CELLS];
  logic       accept;
  logic       last_step;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state == ST_REPLAY);
  assign last_step = ((COUNT_W'(pos) + COUNT_W'(1)) == count);

  assign new_entry.char_code = req.char_code;
  assign new_entry.colour    = req.colour;

  // Broadcast one command to every cell; each decodes its own role from count.
  always_comb begin
    ctrl.count = count;
    if (accept && (req.mode == MODE_SAVE)) begin
      ctrl.cmd = CELL_SAVE;
    end else if (state == ST_REPLAY) begin
      ctrl.cmd = CELL_ROT;
    end else begin
      ctrl.cmd = CELL_HOLD;
    end
  end

  // Chain: cell i hands its word to cell i-1; the far end takes the new word.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    entry_t nbr;
    if (i == CELLS - 1) begin : g_end
      assign nbr = new_entry;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    rhb_cell #(
      .IDX   (i),
      .CELLS (CELLS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_entry (new_entry),
      .nbr       (nbr),
      .wrap      (cell_q[0]),
      .data      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pos   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (req.mode == MODE_SAVE) begin
              // saturate at the chain length
              if (count != FULL_C) begin
                count <= count + COUNT_W'(1);
              end
            end else if (count == '0) begin
              done                  <= 1'b1;
              result.out_char       <= '0;
              result.out_colour     <= '0;
              result.position       <= '0;
              result.restored_count <= '0;
              result.is_last        <= 1'b1;
              result.empty_res      <= 1'b1;
            end else begin
              pos   <= '0;
              state <= ST_REPLAY;
            end
          end
        end
        ST_REPLAY: begin
          // tap cell 0 while the chain rotates underneath
          done                  <= 1'b1;
          result.out_char       <= cell_q[0].char_code;
          result.out_colour     <= cell_q[0].colour;
          result.position       <= pos;
          result.restored_count <= count;
          result.is_last        <= last_step;
          result.empty_res      <= 1'b0;
          pos                   <= pos + POS_W'(1);
          if (last_step) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/rhb_cell.sv @@
// ----------------------------------------------------------------------------
// Ring history buffer cell
// Holds one entry; loads, shifts toward the output end or closes the rotation.
// ----------------------------------------------------------------------------
module rhb_cell import rhb_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CELLS = HISTORY_LIMIT_DEF
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     nbr,
  input  entry_t     wrap,
  output entry_t     data
);

  localparam logic [COUNT_W-1:0] IDX_C  = COUNT_W'(IDX);
  localparam logic [COUNT_W-1:0] IDX_P1 = COUNT_W'(IDX + 1);
  localparam logic [COUNT_W-1:0] FULL_C = COUNT_W'(CELLS);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CELL_SAVE: begin
        // full chain drops the oldest word at cell 0
        if (ctrl.count == FULL_C) begin
          data <= nbr;
        end else if (ctrl.count == IDX_C) begin
          data <= new_entry;
        end
      end
      CELL_ROT: begin
        if (ctrl.count == IDX_P1) begin
          data <= wrap;
        end else if (ctrl.count > IDX_P1) begin
          data <= nbr;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

@@ rtl/rhb_checker.sv @@
// ----------------------------------------------------------------------------
// Ring history buffer checker
// Port-level checks on replay runs, empty results and saves, bound to the top level.
// ----------------------------------------------------------------------------
`include "ring_history_buffer_macros.svh"

module rhb_checker import rhb_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input req_t    req,
  input logic    busy,
  input logic    done,
  input result_t result
);

  `RHB_ASSERT_NOW(a_empty_shape, done && result.empty_res, result.is_last && (result.restored_count == '0) && (result.position == '0), "empty result malformed")
  `RHB_ASSERT_NOW(a_busy_tracks_run, done, busy == !result.is_last, "busy out of step with replay")
  `RHB_ASSERT_NEXT(a_run_advances, done && !result.is_last, done && (result.position == $past(result.position) + 6'd1), "replay gap or position skip")
  `RHB_ASSERT_NEXT(a_save_silent, start && !busy && (req.mode == MODE_SAVE), !done, "save produced a result")

endmodule

bind ring_history_buffer rhb_checker u_rhb_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Ring history buffer testbench
// Drives save and restore words into the history buffer with random gaps.
// It keeps its own ring of stored words and checks every replayed word
// field by field, in order, against the words that ring predicts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rhb_pkg::*;

  localparam int RING_DEPTH    = RING_DEPTH_DEF;
  localparam int HISTORY_LIMIT = HISTORY_LIMIT_DEF;
  // The word count tops out at the smaller of the limit and the ring depth.
  localparam int SAVE_CAP      = (HISTORY_LIMIT < RING_DEPTH) ? HISTORY_LIMIT : RING_DEPTH;
  localparam int RANDOM_ITEMS  = 350;
  localparam int IDLE_PCT      = 22;
  // Keep the driver busy without a single gap over this window of accepted words.
  localparam int CALM_FIRST    = 150;
  localparam int CALM_LAST     = 250;
  // A full restore keeps the block busy longest; the drain window outlasts it.
  localparam int DRAIN_CYCLES  = 2 * SAVE_CAP + 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  req_t    req   = '0;
  logic    busy;
  logic    done;
  result_t result;

  // Words waiting for the driver, and replayed words still to come.
  req_t    pending_words[$];
  result_t replay_words[$];

  // Shadow of the history: a plain ring with a head and a fill count.
  entry_t      ring_mem [RING_DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_fill = 0;

  int          mismatches = 0;
  int unsigned accepted   = 0;
  int unsigned cycles     = 0;

  ring_history_buffer #(
    .RING_DEPTH   (RING_DEPTH),
    .HISTORY_LIMIT(HISTORY_LIMIT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one accepted word to the shadow ring and queue the words it replays.
  task automatic predict_replay(input req_t w);
    int unsigned oldest;
    result_t     r;
    if (w.mode == MODE_SAVE) begin
      // Store at the head, advance the head, raise the count up to the cap.
      ring_mem[ring_head].char_code = w.char_code;
      ring_mem[ring_head].colour    = w.colour;
      ring_head = (ring_head + 1) % RING_DEPTH;
      if (ring_fill < SAVE_CAP) ring_fill++;
    end else if (ring_fill == 0) begin
      // Empty store: a single flagged word with all data zero.
      r           = '0;
      r.is_last   = 1'b1;
      r.empty_res = 1'b1;
      replay_words.push_back(r);
    end else begin
      // Replay the most recent ring_fill words, oldest first.
      oldest = (ring_head + RING_DEPTH - ring_fill) % RING_DEPTH;
      for (int unsigned i = 0; i < ring_fill; i++) begin
        r                = '0;
        r.out_char       = ring_mem[(oldest + i) % RING_DEPTH].char_code;
        r.out_colour     = ring_mem[(oldest + i) % RING_DEPTH].colour;
        r.position       = POS_W'(i);
        r.restored_count = COUNT_W'(ring_fill);
        r.is_last        = (i + 1 == ring_fill);
        replay_words.push_back(r);
      end
    end
  endtask

  function automatic void note_mismatch(input string why, input result_t want,
                                        input result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("mismatch (%s): expected char=%02h colour=%02h pos=%0d count=%0d last=%b empty=%b",
               why, want.out_char, want.out_colour, want.position, want.restored_count,
               want.is_last, want.empty_res);
      $display("              actual   char=%02h colour=%02h pos=%0d count=%0d last=%b empty=%b",
               got.out_char, got.out_colour, got.position, got.restored_count,
               got.is_last, got.empty_res);
    end
  endfunction

  task automatic add_word(input mode_t m, input logic [BYTE_W-1:0] ch,
                          input logic [BYTE_W-1:0] co);
    req_t w;
    w.mode      = m;
    w.char_code = ch;
    w.colour    = co;
    pending_words.push_back(w);
  endtask

  // Driver: take the accepted word into the shadow ring, then offer the next
  // one or idle. start gets exactly one assignment per edge; req only when a word is offered.
  always @(posedge clk) begin : driver
    logic hold_off;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_replay(req);
        void'(pending_words.pop_front());
        accepted++;
      end
      // Idle at random outside the calm window; dropping start while busy
      // is harmless, so gaps land in every phase of a restore as well.
      hold_off = !(accepted >= CALM_FIRST && accepted < CALM_LAST) &&
                 ($urandom_range(0, 99) < IDLE_PCT);
      if (pending_words.size() == 0 || hold_off) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        req   <= pending_words[0];
      end
    end
  end

  // Monitor: every strobed word must match the oldest predicted word.
  always @(posedge clk) begin : monitor
    result_t want;
    string   bad;
    if (!rst && done) begin
      if (replay_words.size() == 0) begin
        note_mismatch("no word expected", '0, result);
      end else begin
        want = replay_words.pop_front();
        bad  = "";
        if (result.out_char       !== want.out_char)       bad = {bad, " out_char"};
        if (result.out_colour     !== want.out_colour)     bad = {bad, " out_colour"};
        if (result.position       !== want.position)       bad = {bad, " position"};
        if (result.restored_count !== want.restored_count) bad = {bad, " restored_count"};
        if (result.is_last        !== want.is_last)        bad = {bad, " is_last"};
        if (result.empty_res      !== want.empty_res)      bad = {bad, " empty_res"};
        if (bad != "") note_mismatch({"wrong", bad}, want, result);
      end
    end
  end

  // Watchdog: stop a run that hangs or loses words.
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[ring_history_buffer] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_added;
    int unsigned burst;
    int          pick;
    random_added = 0;

    // Directed: empty restores right after reset, byte extremes, single-word
    // replay, and restores whose data bytes must be ignored.
    add_word(MODE_RESTORE, 8'h00, 8'h00);
    add_word(MODE_RESTORE, 8'hFF, 8'hFF);
    add_word(MODE_SAVE,    8'h00, 8'h00);
    add_word(MODE_RESTORE, 8'hFF, 8'h00);
    add_word(MODE_SAVE,    8'hFF, 8'hFF);
    add_word(MODE_SAVE,    8'h01, 8'h80);
    add_word(MODE_SAVE,    8'h80, 8'h01);
    add_word(MODE_SAVE,    8'hA5, 8'h5A);
    add_word(MODE_RESTORE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    add_word(MODE_RESTORE, 8'h00, 8'hFF);
    add_word(MODE_SAVE,    8'h5A, 8'hA5);
    add_word(MODE_SAVE,    8'h7F, 8'hFE);
    add_word(MODE_SAVE,    8'hFE, 8'h7F);
    add_word(MODE_RESTORE, 8'h55, 8'hAA);
    add_word(MODE_SAVE,    8'h00, 8'hFF);
    add_word(MODE_RESTORE, 8'hAA, 8'h55);

    // Random: bursts of saves, each closed by one or two restores. Long bursts
    // fill the history to its cap and push old words out; short ones keep the
    // count low; empty bursts give back-to-back restores.
    while (random_added < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)      burst = 0;
      else if (pick < 60) burst = $urandom_range(1, 8);
      else                burst = $urandom_range(SAVE_CAP - 10, SAVE_CAP + 20);
      repeat (burst) begin
        add_word(MODE_SAVE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_added++;
      end
      add_word(MODE_RESTORE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_added++;
      if ($urandom_range(0, 99) < 20) begin
        add_word(MODE_RESTORE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_added++;
      end
    end

    // Hold reset, then release it once.
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait until every word is taken and every replay has come back.
    do @(posedge clk);
    while (pending_words.size() != 0 || replay_words.size() != 0);
    // Watch for stray words while the block settles.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && replay_words.size() == 0) begin
      $display("[ring_history_buffer] OK");
    end else begin
      $display("[ring_history_buffer] ERROR");
    end
    $finish;
  end

endmodule
